@@ hdl/point_to_line_projection_macros.svh @@
// Assertion macros for the point-to-line projection block.
// Used by hdl/point_to_line_projection.sv; no other dependencies.
`ifndef POINT_TO_LINE_PROJECTION_MACROS_SVH
`define POINT_TO_LINE_PROJECTION_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PTLP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptlp assertion failed");

// next-cycle implication
`define PTLP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptlp assertion failed");

`endif

@@ hdl/ptlp_pkg.sv @@
// Package for the point-to-line projection block: widths, register
// indexes, pipeline depths and the output saturation function. No dependencies.
`default_nettype none

package ptlp_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int COORD_W = 32;
  localparam int PO_W    = COORD_W + 1;
  localparam int PROD_W  = PO_W + COORD_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int DEN_W   = 2 * COORD_W;
  localparam int SPLIT_W = 34;
  localparam int PLO_W   = SPLIT_W + COORD_W;
  localparam int PHI_W   = DOT_W - SPLIT_W + COORD_W;
  localparam int NUM_W   = 98;
  localparam int QUO_W   = 34;
  localparam int QS_W    = QUO_W + 1;
  localparam int VEC_W   = 36;
  localparam int PMAG_W  = 34;
  localparam int PSQ_W   = 2 * PMAG_W;
  localparam int ACC_W   = PSQ_W + 2;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int SREM_W  = SQ_W + 2;

  localparam int FRONT_STAGES = 6;
  localparam int BACK_STAGES  = 7;
  localparam int LATENCY = FRONT_STAGES + QUO_W + BACK_STAGES + ROOT_W + 1;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } reg_idx_e;

  function automatic logic [COORD_W-1:0] sat32(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] hi;
    logic signed [VEC_W-1:0] lo;
    hi = VEC_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
    lo = -hi - VEC_W'(1);
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/point_to_line_projection.sv @@
// Point-to-line projection, fully pipelined top level.
// Depends on ptlp_pkg and point_to_line_projection_macros.svh.
`default_nettype none

// Projects a 3D Q16.16 point onto a line held in APB registers. One request
// is taken every cycle (busy stays low); each result shows on done_o for one
// cycle, in order, and must be taken then. The offset along the line comes from
// the 34-stage radix-2 divider and the distance from the 32-stage square-root
// pipeline. Line registers may only be written while no request is in flight.
`include "point_to_line_projection_macros.svh"

module point_to_line_projection #(
  parameter int FRAC_BITS = ptlp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ptlp_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [ptlp_pkg::DATA_W-1:0]      pwdata,
  output logic      [ptlp_pkg::DATA_W-1:0]      prdata,
  output logic                                  pready,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             opcode_i,
  input  wire logic signed [ptlp_pkg::COORD_W-1:0] point_x_i,
  input  wire logic signed [ptlp_pkg::COORD_W-1:0] point_y_i,
  input  wire logic signed [ptlp_pkg::COORD_W-1:0] point_z_i,
  output logic                                  done_o,
  output logic signed [ptlp_pkg::COORD_W-1:0]   vec_x_o,
  output logic signed [ptlp_pkg::COORD_W-1:0]   vec_y_o,
  output logic signed [ptlp_pkg::COORD_W-1:0]   vec_z_o,
  output logic      [ptlp_pkg::SQ_W-1:0]        sq_distance_o,
  output logic      [ptlp_pkg::ROOT_W-1:0]      distance_o,
  output logic                                  degenerate_o
);

  localparam int CW    = ptlp_pkg::COORD_W;
  localparam int PO_W  = ptlp_pkg::PO_W;
  localparam int NUM_W = ptlp_pkg::NUM_W;
  localparam int QUO_W = ptlp_pkg::QUO_W;
  localparam int QS_W  = ptlp_pkg::QS_W;
  localparam int VEC_W = ptlp_pkg::VEC_W;
  localparam int RT_W  = ptlp_pkg::ROOT_W;
  localparam int SR_W  = ptlp_pkg::SREM_W;
  localparam int SPL   = ptlp_pkg::SPLIT_W;
  localparam int LAT   = ptlp_pkg::LATENCY;

  // line registers
  logic signed [CW-1:0] origin_q [3];
  logic signed [CW-1:0] dir_q [3];
  logic [CW-1:0] dabs [3];
  logic cfg_wr;
  ptlp_pkg::reg_idx_e cfg_idx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = ptlp_pkg::reg_idx_e'(paddr[ptlp_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      dir_q[0]    <= CW'(1) << FRAC_BITS;
      dir_q[1]    <= '0;
      dir_q[2]    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ptlp_pkg::REG_ORIGIN_X: origin_q[0] <= pwdata;
        ptlp_pkg::REG_ORIGIN_Y: origin_q[1] <= pwdata;
        ptlp_pkg::REG_ORIGIN_Z: origin_q[2] <= pwdata;
        ptlp_pkg::REG_DIR_X:    dir_q[0]    <= pwdata;
        ptlp_pkg::REG_DIR_Y:    dir_q[1]    <= pwdata;
        ptlp_pkg::REG_DIR_Z:    dir_q[2]    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ptlp_pkg::REG_ORIGIN_X: prdata = origin_q[0];
      ptlp_pkg::REG_ORIGIN_Y: prdata = origin_q[1];
      ptlp_pkg::REG_ORIGIN_Z: prdata = origin_q[2];
      ptlp_pkg::REG_DIR_X:    prdata = dir_q[0];
      ptlp_pkg::REG_DIR_Y:    prdata = dir_q[1];
      ptlp_pkg::REG_DIR_Z:    prdata = dir_q[2];
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dabs[i] = dir_q[i][CW-1] ? CW'(-dir_q[i]) : CW'(dir_q[i]);
    end
  end

  // |D|^2, recomputed from the registers each cycle
  logic [ptlp_pkg::DEN_W-1:0] dsq_q [3];
  logic [ptlp_pkg::DEN_W-1:0] den_q;
  logic deg_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dsq_q[i] <= dabs[i] * dabs[i];
    end
    den_q <= dsq_q[0] + dsq_q[1] + dsq_q[2];
    deg_q <= (dir_q[0] == '0) && (dir_q[1] == '0) && (dir_q[2] == '0);
  end

  // valid shift line
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start && !busy};
    end
  end

  // front stages: PO, dot product, |dot|, numerator
  logic signed [PO_W-1:0] po_q [6][3];
  logic op_q [6];
  logic signed [ptlp_pkg::PROD_W-1:0] prod2_q [3];
  logic signed [ptlp_pkg::DOT_W-1:0] dot3_q;
  logic [ptlp_pkg::DOT_W-1:0] dmag4_q;
  logic dneg_q [3:5];
  logic [ptlp_pkg::PLO_W-1:0] plo5_q [3];
  logic [ptlp_pkg::PHI_W-1:0] phi5_q [3];
  logic [NUM_W-1:0] num6_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int s = 1; s < 6; s++) begin
        po_q[s][i] <= po_q[s-1][i];
      end
    end
    for (int s = 1; s < 6; s++) begin
      op_q[s] <= op_q[s-1];
    end
    op_q[0] <= opcode_i;
    po_q[0][0] <= PO_W'(point_x_i) - PO_W'(origin_q[0]);
    po_q[0][1] <= PO_W'(point_y_i) - PO_W'(origin_q[1]);
    po_q[0][2] <= PO_W'(point_z_i) - PO_W'(origin_q[2]);
    for (int i = 0; i < 3; i++) begin
      prod2_q[i] <= po_q[0][i] * dir_q[i];
    end
    dot3_q <= ptlp_pkg::DOT_W'(prod2_q[0]) + ptlp_pkg::DOT_W'(prod2_q[1])
            + ptlp_pkg::DOT_W'(prod2_q[2]);
    dneg_q[3] <= dot3_q[ptlp_pkg::DOT_W-1];
    dmag4_q   <= dot3_q[ptlp_pkg::DOT_W-1] ? ptlp_pkg::DOT_W'(-dot3_q)
                                            : ptlp_pkg::DOT_W'(dot3_q);
    dneg_q[4] <= dneg_q[3];
    dneg_q[5] <= dneg_q[4];
    for (int i = 0; i < 3; i++) begin
      plo5_q[i] <= dmag4_q[SPL-1:0] * dabs[i];
      phi5_q[i] <= dmag4_q[ptlp_pkg::DOT_W-1:SPL] * dabs[i];
      num6_q[i] <= NUM_W'(plo5_q[i]) + (NUM_W'(phi5_q[i]) << SPL);
    end
  end

  // restoring divider, one quotient bit per stage
  logic [NUM_W-1:0] drem_d [QUO_W][3];
  logic [QUO_W-1:0] dquo_d [QUO_W][3];
  logic [NUM_W-1:0] drem_q [QUO_W][3];
  logic [QUO_W-1:0] dquo_q [QUO_W][3];
  logic signed [PO_W-1:0] dpo_q [QUO_W][3];
  logic dneg_dq [QUO_W];
  logic dop_q [QUO_W];

  always_comb begin
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [NUM_W-1:0] sh;
    for (int j = 0; j < QUO_W; j++) begin
      for (int i = 0; i < 3; i++) begin
        rem = (j == 0) ? num6_q[i] : drem_q[(j == 0) ? 0 : j-1][i];
        quo = (j == 0) ? '0 : dquo_q[(j == 0) ? 0 : j-1][i];
        sh  = NUM_W'(den_q) << (QUO_W - 1 - j);
        if (rem >= sh) begin
          drem_d[j][i] = rem - sh;
          dquo_d[j][i] = quo | (QUO_W'(1) << (QUO_W - 1 - j));
        end else begin
          drem_d[j][i] = rem;
          dquo_d[j][i] = quo;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QUO_W; j++) begin
      for (int i = 0; i < 3; i++) begin
        drem_q[j][i] <= drem_d[j][i];
        dquo_q[j][i] <= dquo_d[j][i];
        dpo_q[j][i]  <= (j == 0) ? po_q[5][i] : dpo_q[(j == 0) ? 0 : j-1][i];
      end
      dneg_dq[j] <= (j == 0) ? dneg_q[5] : dneg_dq[(j == 0) ? 0 : j-1];
      dop_q[j]   <= (j == 0) ? op_q[5] : dop_q[(j == 0) ? 0 : j-1];
    end
  end

  // back stages: round, sign, vectors, squared length
  logic [QUO_W-1:0] uq1_q [3];
  logic signed [QS_W-1:0] qs2_q [3];
  logic signed [VEC_W-1:0] proj3_q [3];
  logic signed [VEC_W-1:0] perp3_q [3];
  logic [CW-1:0] vec_q [4][3];
  logic [ptlp_pkg::PMAG_W-1:0] pmag4_q [3];
  logic [ptlp_pkg::PSQ_W-1:0] psq5_q [3];
  logic [ptlp_pkg::ACC_W-1:0] acc6_q;
  logic [ptlp_pkg::SQ_W-1:0] sq7_q;
  logic signed [PO_W-1:0] bpo_q [2][3];
  logic bneg_q;
  logic bop_q [3];

  always_ff @(posedge clk_i) begin
    logic [ptlp_pkg::SQ_W:0] rem2;
    logic signed [VEC_W-1:0] sel;
    for (int i = 0; i < 3; i++) begin
      rem2 = {drem_q[QUO_W-1][i][ptlp_pkg::SQ_W-1:0], 1'b0};
      uq1_q[i] <= dquo_q[QUO_W-1][i] + QUO_W'(rem2 >= {1'b0, den_q});
      bpo_q[0][i] <= dpo_q[QUO_W-1][i];
      bpo_q[1][i] <= bpo_q[0][i];
      qs2_q[i] <= (bneg_q ^ dir_q[i][CW-1]) ? -QS_W'(uq1_q[i]) : QS_W'(uq1_q[i]);
      proj3_q[i] <= VEC_W'(origin_q[i]) + VEC_W'(qs2_q[i]);
      perp3_q[i] <= VEC_W'(bpo_q[1][i]) - VEC_W'(qs2_q[i]);
      sel = bop_q[2] ? perp3_q[i] : proj3_q[i];
      vec_q[0][i] <= ptlp_pkg::sat32(sel);
      pmag4_q[i] <= perp3_q[i][VEC_W-1] ? ptlp_pkg::PMAG_W'(-perp3_q[i])
                                         : ptlp_pkg::PMAG_W'(perp3_q[i]);
      psq5_q[i] <= pmag4_q[i] * pmag4_q[i];
      vec_q[1][i] <= vec_q[0][i];
      vec_q[2][i] <= vec_q[1][i];
      vec_q[3][i] <= vec_q[2][i];
    end
    bneg_q   <= dneg_dq[QUO_W-1];
    bop_q[0] <= dop_q[QUO_W-1];
    bop_q[1] <= bop_q[0];
    bop_q[2] <= bop_q[1];
    acc6_q <= ptlp_pkg::ACC_W'(psq5_q[0]) + ptlp_pkg::ACC_W'(psq5_q[1])
            + ptlp_pkg::ACC_W'(psq5_q[2]);
    sq7_q <= (acc6_q[ptlp_pkg::ACC_W-1:ptlp_pkg::SQ_W] != '0) ? '1
           : acc6_q[ptlp_pkg::SQ_W-1:0];
  end

  // integer square root, one root bit per stage
  logic [SR_W-1:0] srem_d [RT_W];
  logic [RT_W-1:0] root_d [RT_W];
  logic [SR_W-1:0] srem_q [RT_W];
  logic [RT_W-1:0] root_q [RT_W];
  logic [ptlp_pkg::SQ_W-1:0] ssq_q [RT_W];
  logic [CW-1:0] svec_q [RT_W][3];

  always_comb begin
    logic [SR_W-1:0] rem;
    logic [RT_W-1:0] root;
    logic [SR_W-1:0] trial;
    for (int j = 0; j < RT_W; j++) begin
      rem   = (j == 0) ? SR_W'(sq7_q) : srem_q[(j == 0) ? 0 : j-1];
      root  = (j == 0) ? '0 : root_q[(j == 0) ? 0 : j-1];
      trial = (SR_W'(root) << (RT_W - j)) + (SR_W'(1) << (2 * (RT_W - 1 - j)));
      if (rem >= trial) begin
        srem_d[j] = rem - trial;
        root_d[j] = root | (RT_W'(1) << (RT_W - 1 - j));
      end else begin
        srem_d[j] = rem;
        root_d[j] = root;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < RT_W; j++) begin
      srem_q[j] <= srem_d[j];
      root_q[j] <= root_d[j];
      ssq_q[j]  <= (j == 0) ? sq7_q : ssq_q[(j == 0) ? 0 : j-1];
      for (int i = 0; i < 3; i++) begin
        svec_q[j][i] <= (j == 0) ? vec_q[3][i] : svec_q[(j == 0) ? 0 : j-1][i];
      end
    end
  end

  // output register
  assign done_o = vld_q[LAT-1];

  always_ff @(posedge clk_i) begin
    degenerate_o  <= deg_q;
    vec_x_o       <= deg_q ? '0 : svec_q[RT_W-1][0];
    vec_y_o       <= deg_q ? '0 : svec_q[RT_W-1][1];
    vec_z_o       <= deg_q ? '0 : svec_q[RT_W-1][2];
    sq_distance_o <= deg_q ? '0 : ssq_q[RT_W-1];
    distance_o    <= deg_q ? '0 : root_q[RT_W-1];
  end

  `PTLP_ASSERT_IMP(a_done_latency, done_o, $past(start && !busy, ptlp_pkg::LATENCY))
  `PTLP_ASSERT_IMP(a_degenerate_zero, done_o && degenerate_o, sq_distance_o == '0 && distance_o == '0 && vec_x_o == '0)
  `PTLP_ASSERT_IMP(a_root_floor, done_o && !degenerate_o, (64'(distance_o) * 64'(distance_o)) <= sq_distance_o)
  `PTLP_ASSERT_IMP(a_sat_root, done_o && sq_distance_o == '1, distance_o == '1)
  `PTLP_ASSERT_NXT(a_no_busy, 1'b1, !busy)

endmodule

`default_nettype wire

@@ sim/point_to_line_projection_test.sv @@
// Self-checking testbench for the point-to-line projection block: APB line setup,
// directed and random point requests, and a wide-integer predictor of every output.
// Depends on ptlp_pkg and hdl/point_to_line_projection.sv.
`default_nettype none

module point_to_line_projection_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [63:0]        sq;
    logic [31:0]        dlen;
    logic               deg;
  } proj_res_t;

  typedef struct {
    logic               op;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    bit                 typed;
    proj_res_t          res;
  } point_row_t;

  localparam int ONE = 1 << 16;
  localparam int LIMIT_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ptlp_pkg::ADDR_W-1:0] paddr = '0;
  logic [ptlp_pkg::DATA_W-1:0] pwdata = '0;
  logic [ptlp_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic opcode_i = 1'b0;
  logic signed [31:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic done_o;
  logic signed [31:0] vec_x_o, vec_y_o, vec_z_o;
  logic [63:0] sq_distance_o;
  logic [31:0] distance_o;
  logic degenerate_o;

  point_to_line_projection dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic signed [31:0] line_origin[3];
  logic signed [31:0] line_dir[3];
  proj_res_t pending_results[$];
  int mismatches = 0;
  int cycle_count = 0;

  function automatic proj_res_t project_point(logic op, logic signed [31:0] px,
                                              logic signed [31:0] py,
                                              logic signed [31:0] pz);
    logic signed [127:0] po[3];
    logic signed [127:0] d[3];
    logic signed [127:0] dot, q, perp, sel;
    logic [127:0] den, num, uq, acc, mag_dot, mag_d, trial;
    logic [63:0] sq;
    logic [31:0] root;
    proj_res_t r;
    po[0] = 128'(px) - 128'(line_origin[0]);
    po[1] = 128'(py) - 128'(line_origin[1]);
    po[2] = 128'(pz) - 128'(line_origin[2]);
    den = '0;
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 128'(line_dir[i]);
      den += d[i] * d[i];
      dot += po[i] * d[i];
    end
    r = '0;
    if (den == 0) begin
      r.deg = 1'b1;
      return r;
    end
    mag_dot = dot < 0 ? -dot : dot;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      mag_d = d[i] < 0 ? -d[i] : d[i];
      num = mag_dot * mag_d;
      uq = (2 * num + den) / (2 * den);
      q = ((dot < 0) != (d[i] < 0)) ? -$signed(uq) : $signed(uq);
      perp = po[i] - q;
      acc += perp * perp;
      sel = op ? perp : 128'(line_origin[i]) + q;
      if (sel > 128'sd2147483647) sel = 128'sd2147483647;
      if (sel < -128'sd2147483648) sel = -128'sd2147483648;
      if (i == 0) r.vx = sel[31:0];
      else if (i == 1) r.vy = sel[31:0];
      else r.vz = sel[31:0];
    end
    sq = acc[127:64] != 0 ? '1 : acc[63:0];
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = 128'(root | (32'd1 << b));
      if (trial * trial <= 128'(sq)) root = trial[31:0];
    end
    r.sq = sq;
    r.dlen = root;
    return r;
  endfunction

  task automatic write_reg(ptlp_pkg::reg_idx_e idx, logic signed [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ptlp_pkg::ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= ptlp_pkg::REG_ORIGIN_Z) line_origin[int'(idx)] = value;
    else line_dir[int'(idx) - 3] = value;
  endtask

  task automatic set_line(logic signed [31:0] ox, oy, oz, dx, dy, dz);
    write_reg(ptlp_pkg::REG_ORIGIN_X, ox);
    write_reg(ptlp_pkg::REG_ORIGIN_Y, oy);
    write_reg(ptlp_pkg::REG_ORIGIN_Z, oz);
    write_reg(ptlp_pkg::REG_DIR_X, dx);
    write_reg(ptlp_pkg::REG_DIR_Y, dy);
    write_reg(ptlp_pkg::REG_DIR_Z, dz);
  endtask

  // drive one request; start stays high if the caller sends another right away
  task automatic send_point(point_row_t row);
    start <= 1'b1;
    opcode_i <= row.op;
    point_x_i <= row.px;
    point_y_i <= row.py;
    point_z_i <= row.pz;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(row.typed ? row.res : project_point(row.op, row.px, row.py, row.pz));
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (ptlp_pkg::LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 16 * ONE)) - 8 * ONE;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 512)) - 256;
    endcase
  endfunction

  function automatic point_row_t row_of(logic op, logic signed [31:0] x, y, z);
    point_row_t row;
    row = '{op, x, y, z, 1'b0, '0};
    return row;
  endfunction

  function automatic point_row_t typed_row(logic op, logic signed [31:0] x, y, z,
                                           proj_res_t res);
    point_row_t row;
    row = '{op, x, y, z, 1'b1, res};
    return row;
  endfunction

  always @(posedge clk_i) begin
    proj_res_t got, want;
    if (rst_ni && done_o) begin
      got = '{vec_x_o, vec_y_o, vec_z_o, sq_distance_o, distance_o, degenerate_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("point_to_line_projection verification failed");
      $finish;
    end
  end

  initial begin
    point_row_t table_rows[$];
    int burst, mode;
    line_origin = '{0, 0, 0};
    line_dir = '{ONE, 0, 0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset line: x axis through the origin
    table_rows = '{
      typed_row(1'b0, 5 * ONE, 7 * ONE, -2 * ONE, '{5 * ONE, 0, 0, 64'd53 << 32, 32'h747b5, 0}),
      typed_row(1'b1, ONE, 3 * ONE, 4 * ONE, '{0, 3 * ONE, 4 * ONE, 64'd25 << 32, 5 * ONE, 0}),
      typed_row(1'b0, 32'sh7fffffff, 0, 0, '{32'sh7fffffff, 0, 0, 0, 0, 0}),
      typed_row(1'b0, 32'sh80000000, 0, 0, '{32'sh80000000, 0, 0, 0, 0, 0}),
      typed_row(1'b1, 0, 0, 0, '{0, 0, 0, 0, 0, 0}),
      row_of(1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000),
      row_of(1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff),
      row_of(1'b0, -1, 1, -1)
    };
    foreach (table_rows[i]) send_point(table_rows[i]);
    drain();

    set_line(0, 0, 0, 0, 0, 0);
    table_rows = '{
      typed_row(1'b0, 3 * ONE, 1, -1, '{0, 0, 0, 0, 0, 1}),
      typed_row(1'b1, 32'sh7fffffff, 32'sh80000000, 0, '{0, 0, 0, 0, 0, 1})
    };
    foreach (table_rows[i]) send_point(table_rows[i]);
    drain();

    // extreme origin and direction
    set_line(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    table_rows = '{
      row_of(1'b0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000),
      row_of(1'b1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000),
      row_of(1'b1, 32'sh7fffffff, 32'sh80000000, 0),
      row_of(1'b0, 0, 0, 0),
      row_of(1'b1, 32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f)
    };
    foreach (table_rows[i]) send_point(table_rows[i]);
    drain();

    set_line(ONE, -ONE, 2 * ONE, 1, 0, -1);
    table_rows = '{row_of(1'b0, 3, 0, 0), row_of(1'b1, 5, 2, -4), row_of(1'b0, 1, 0, 2)};
    foreach (table_rows[i]) send_point(table_rows[i]);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      mode = phase % 4;
      if (phase == 7) set_line(0, 0, 0, ONE, 0, 0);
      else set_line(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                    rand_coord((mode + 1) % 4), rand_coord((mode + 3) % 4),
                    $urandom_range(0, 3) == 0 ? 32'sd0 : rand_coord(mode));
      for (int n = 0; n < 212;) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && n < 212; k++, n++)
          send_point(row_of($urandom_range(0, 1), rand_coord($urandom_range(0, 3)),
                            rand_coord($urandom_range(0, 3)),
                            rand_coord($urandom_range(0, 3))));
        pause_sender($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
      end
      drain();
    end

    if (mismatches == 0) $display("point_to_line_projection verification clean");
    else $display("point_to_line_projection verification failed");
    $finish;
  end

endmodule

`default_nettype wire
